/* sv/sdmd_pkg.sv */
// ----------------------------------------------------------------------------
// sdmd_pkg
// Shared types and constants for the sigma-delta motion detector.
// ----------------------------------------------------------------------------
package sdmd_pkg;

    localparam int NUM_PIXELS = 65536;

    localparam int PIX_W  = 8;
    localparam int IDX_W  = 16;
    localparam int AMP_W  = 4;
    localparam int VAR_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [AMP_W-1:0] AMP_RESET   = 4'd2;
    localparam logic [VAR_W-1:0] FLOOR_RESET = 8'd20;
    localparam logic [VAR_W-1:0] CEIL_RESET  = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AMPLIFICATION    = 2'd0,
        REG_VARIANCE_FLOOR   = 2'd1,
        REG_VARIANCE_CEILING = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [AMP_W-1:0] amplification;
        logic [VAR_W-1:0] variance_floor;
        logic [VAR_W-1:0] variance_ceiling;
    } cfg_t;

    typedef struct packed {
        logic             motion;
        logic [PIX_W-1:0] background;
        logic [PIX_W-1:0] difference;
        logic [VAR_W-1:0] variance;
    } result_t;

endpackage

/* sv/sdmd_ram.sv */
// ----------------------------------------------------------------------------
// sdmd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sdmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/sdmd_update.sv */
// ----------------------------------------------------------------------------
// sdmd_update
// Per-pixel sigma-delta update: background step, difference, variance step
// and clamp, motion decision; init loads the pixel as background instead.
// ----------------------------------------------------------------------------
module sdmd_update (
    input  sdmd_pkg::cfg_t                   cfg,
    input  logic [sdmd_pkg::PIX_W-1:0]       pixel,
    input  logic                             init,
    input  logic [sdmd_pkg::PIX_W-1:0]       bg_old,
    input  logic [sdmd_pkg::VAR_W-1:0]       var_old,
    output sdmd_pkg::result_t                res
);

    localparam int TGT_W = sdmd_pkg::PIX_W + sdmd_pkg::AMP_W;

    logic [sdmd_pkg::PIX_W-1:0] bg_step;
    logic [sdmd_pkg::PIX_W-1:0] diff;
    logic [TGT_W-1:0]           target;
    logic [TGT_W-1:0]           var_ext;
    logic [sdmd_pkg::VAR_W:0]   var_step;
    logic [sdmd_pkg::VAR_W:0]   var_floor;
    logic [sdmd_pkg::VAR_W-1:0] var_final;

    always_comb
    begin
        priority if (bg_old < pixel)
            bg_step = bg_old + 1'b1;
        else if (bg_old > pixel)
            bg_step = bg_old - 1'b1;
        else
            bg_step = bg_old;

        diff    = (pixel > bg_step) ? (pixel - bg_step) : (bg_step - pixel);
        target  = TGT_W'(diff) * TGT_W'(cfg.amplification);
        var_ext = TGT_W'(var_old);

        priority if (var_ext < target)
            var_step = {1'b0, var_old} + 1'b1;
        else if (var_ext > target)
            var_step = {1'b0, var_old} - 1'b1;
        else
            var_step = {1'b0, var_old};

        // floor first, ceiling wins
        var_floor = (var_step < {1'b0, cfg.variance_floor}) ?
                    {1'b0, cfg.variance_floor} : var_step;
        var_final = (var_floor > {1'b0, cfg.variance_ceiling}) ?
                    cfg.variance_ceiling : var_floor[sdmd_pkg::VAR_W-1:0];

        if (init)
        begin
            res.motion     = 1'b0;
            res.background = pixel;
            res.difference = '0;
            res.variance   = cfg.variance_floor;
        end
        else
        begin
            res.motion     = (diff >= var_final);
            res.background = bg_step;
            res.difference = diff;
            res.variance   = var_final;
        end
    end

endmodule

/* sv/sigma_delta_motion_detect.sv */
// ----------------------------------------------------------------------------
// sigma_delta_motion_detect
// Per-pixel sigma-delta background subtraction with motion flag.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pixel, pixel_index; tuser: init
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: motion, background, difference
// cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One request per cycle sustained unless the output stalls; the result is registered.
// Stage 0 reads the state RAM, stage 1 updates and writes it back; the entry
// written in the previous request is forwarded to cover the read-during-write.
// Reset clears control and configuration only; RAM contents are not cleared.
// A stalled output holds stage 1, which in turn stalls the input.
// ----------------------------------------------------------------------------
module sigma_delta_motion_detect #(
    parameter int NUM_PIXELS = sdmd_pkg::NUM_PIXELS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [23:0]                         s_axis_tdata,   // pixel[7:0], pixel_index[23:8]
    input  logic                                s_axis_tuser,   // init[0]

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [23:0]                         m_axis_tdata,   // motion[0], background[8:1], difference[16:9], zero[23:17]

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdmd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sdmd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int MEM_W  = sdmd_pkg::PIX_W + sdmd_pkg::VAR_W;

    // configuration
    sdmd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.amplification    <= sdmd_pkg::AMP_RESET;
            cfg_reg.variance_floor   <= sdmd_pkg::FLOOR_RESET;
            cfg_reg.variance_ceiling <= sdmd_pkg::CEIL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sdmd_pkg::REG_AMPLIFICATION:
                    cfg_reg.amplification <= cfg_data[sdmd_pkg::AMP_W-1:0];
                sdmd_pkg::REG_VARIANCE_FLOOR:
                    cfg_reg.variance_floor <= cfg_data;
                sdmd_pkg::REG_VARIANCE_CEILING:
                    cfg_reg.variance_ceiling <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // stage 0
    logic [31:0]       idx_ext;
    logic              in_range;
    logic [ADDR_W-1:0] rd_addr;
    logic              in_accept;

    assign idx_ext   = {16'd0, s_axis_tdata[23:8]};
    assign in_range  = idx_ext < 32'(NUM_PIXELS);
    assign rd_addr   = idx_ext[ADDR_W-1:0];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // stage 1
    logic                        s1_valid_reg;
    logic [sdmd_pkg::PIX_W-1:0]  s1_pixel_reg;
    logic [ADDR_W-1:0]           s1_addr_reg;
    logic                        s1_init_reg;
    logic                        s1_in_range_reg;
    logic                        s1_advance;

    logic                        fwd_valid_reg;
    logic [ADDR_W-1:0]           fwd_addr_reg;
    logic [MEM_W-1:0]            fwd_data_reg;

    logic                        out_valid_reg;
    logic [23:0]                 out_data_reg;
    logic [23:0]                 out_data_next;

    logic [MEM_W-1:0]            ram_rdata;
    logic [MEM_W-1:0]            entry;
    logic                        ram_we;
    sdmd_pkg::result_t           res;

    assign s1_advance    = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign ram_we        = s1_advance && s1_in_range_reg;

    sdmd_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_PIXELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata ({res.background, res.variance}),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        priority if (!s1_in_range_reg)
            entry = '0;
        else if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
            entry = fwd_data_reg;
        else
            entry = ram_rdata;
    end

    sdmd_update u_update (
        .cfg     (cfg_reg),
        .pixel   (s1_pixel_reg),
        .init    (s1_init_reg),
        .bg_old  (entry[MEM_W-1:sdmd_pkg::VAR_W]),
        .var_old (entry[sdmd_pkg::VAR_W-1:0]),
        .res     (res)
    );

    assign out_data_next = {7'd0, res.difference, res.background, res.motion};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;

            if (ram_we)
                fwd_valid_reg <= 1'b1;

            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pixel_reg    <= s_axis_tdata[7:0];
            s1_addr_reg     <= rd_addr;
            s1_init_reg     <= s_axis_tuser;
            s1_in_range_reg <= in_range;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= {res.background, res.variance};
        end
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_init_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_init_reg) |=>
            (m_axis_tdata[0] == 1'b0) && (m_axis_tdata[16:9] == '0))
        else $error("init request gave nonzero motion or difference");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=>
            s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_pixel_reg))
        else $error("stage 1 request lost while stalled");

    a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> fwd_valid_reg && (fwd_addr_reg == $past(s1_addr_reg)))
        else $error("forwarding register missed a write-back");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && s1_valid_reg) |-> !in_accept)
        else $error("request accepted with pipeline full");
`endif

endmodule
